/* rtl/core/tcaba_pkg.sv */
package tcaba_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int COUNT_BITS  = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int NUM_BITS    = SUM_BITS + 1;
  localparam int WIN_BITS    = 16;
  localparam int AVG_BITS    = 10;
  localparam int DIGIT_BITS  = 4;

  localparam logic [WIN_BITS-1:0]   WINDOW_RESET = WIN_BITS'(2000);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};
  localparam int                    TEMP_SHIFT   = 2;

  typedef enum logic {
    CH_TEMP  = 1'b0,
    CH_LIGHT = 1'b1
  } chan_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/core/tcaba_if.sv */
interface tcaba_in_if;
  import tcaba_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   channel;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface tcaba_out_if;
  import tcaba_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  result_channel;
  logic [AVG_BITS-1:0]   average;
  logic                  empty_res;
  logic [DIGIT_BITS-1:0] hundreds;
  logic [DIGIT_BITS-1:0] tens;
  logic [DIGIT_BITS-1:0] ones;

  modport source (output valid, output result_channel, output average, output empty_res,
                  output hundreds, output tens, output ones, input ready);
  modport sink   (input valid, input result_channel, input average, input empty_res,
                  input hundreds, input tens, input ones, output ready);
endinterface

/* rtl/core/tcaba_div.sv */
module tcaba_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tcaba_pkg::NUM_BITS-1:0]   dividend,
  input  logic [tcaba_pkg::COUNT_BITS-1:0] divisor,
  output tcaba_pkg::div_stat_t          stat,
  output logic [tcaba_pkg::NUM_BITS-1:0]   quotient
);
  import tcaba_pkg::*;

  localparam int STEP_BITS = $clog2(NUM_BITS);

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_BITS-1:0]  step_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [NUM_BITS-1:0]   quo_r;
  logic [COUNT_BITS-1:0] dvs_r;

  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS:0]   diff;
  logic                  fits;

  // one quotient bit a cycle, restoring form
  assign shifted = {rem_r, quo_r[NUM_BITS-1]};
  assign fits    = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !start && busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_BITS'(NUM_BITS - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
      quo_r <= {quo_r[NUM_BITS-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

/* rtl/core/two_channel_adc_block_averager.sv */
// Two-channel boxcar averager for 10-bit converter samples. Every transfer on the input
// channel advances a shared tick; once the tick exceeds window_r, the tagged
// channel's rounded mean (sum + count/2)/count is reported together with its hundreds,
// tens and ones digits, and that channel's sum and count restart with the current sample
// (temperature accumulates sample>>2, light the full sample; counts stop at 65535). A
// sample that ends no window leaves the block idle, so the next one can be taken in the
// following cycle. A sample that ends a window is accepted, then passes the shared
// bit-serial divider (one quotient bit per cycle over the 27-bit rounded sum, then the
// quotient is handed over in ST_DIV) and the digit states ST_DIG1 and ST_DIG2, the last
// of which waits for a free output register; an empty channel skips the divider. The
// result waits in an output register, so the next sample is accepted while it is held.
module two_channel_adc_block_averager (
  input  logic                          clk,
  input  logic                          rst_n,
  tcaba_in_if.sink                      in_chan,
  tcaba_out_if.source                   out_chan,
  input  logic                          cfg_we,
  input  logic [tcaba_pkg::WIN_BITS-1:0] cfg_wdata
);
  import tcaba_pkg::*;

  localparam logic [AVG_BITS-1:0] THOUSAND   = AVG_BITS'(1000);
  localparam logic [AVG_BITS-1:0] HUNDRED    = AVG_BITS'(100);
  localparam logic [6:0]          TEN        = 7'd10;
  localparam logic [15:0]         RECIP_100  = 16'd41;   // 41/4096 ~ 1/100 for 0..999
  localparam logic [14:0]         RECIP_10   = 15'd205;  // 205/2048 ~ 1/10 for 0..99

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIG1,
    ST_DIG2
  } state_t;

  state_t                state_r;
  logic [WIN_BITS-1:0]   window_r;
  logic [WIN_BITS-1:0]   tick_r;
  logic [SUM_BITS-1:0]   temp_sum_r;
  logic [COUNT_BITS-1:0] temp_cnt_r;
  logic [SUM_BITS-1:0]   light_sum_r;
  logic [COUNT_BITS-1:0] light_cnt_r;

  logic                  res_chan_r;
  logic                  res_empty_r;
  logic [AVG_BITS-1:0]   avg_r;
  logic [DIGIT_BITS-1:0] hund_r;
  logic [6:0]            rem_r;

  logic                  out_valid_r;
  logic                  out_chan_r;
  logic [AVG_BITS-1:0]   out_avg_r;
  logic                  out_empty_r;
  logic [DIGIT_BITS-1:0] out_hund_r;
  logic [DIGIT_BITS-1:0] out_tens_r;
  logic [DIGIT_BITS-1:0] out_ones_r;

  logic                  accept;
  logic [WIN_BITS-1:0]   tick_inc;
  logic                  win_end;
  logic                  is_light;
  logic [SUM_BITS-1:0]   cur_sum;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [SUM_BITS-1:0]   base_sum;
  logic [COUNT_BITS-1:0] base_cnt;
  logic [SUM_BITS-1:0]   add_val;
  logic [SUM_BITS-1:0]   sum_nxt;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic [NUM_BITS-1:0]   numer;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [NUM_BITS-1:0]   div_quo;

  logic [AVG_BITS-1:0]   rest;
  logic [15:0]           hund_prod;
  logic [DIGIT_BITS-1:0] hund_w;
  logic [6:0]            rem_w;
  logic [14:0]           tens_prod;
  logic [DIGIT_BITS-1:0] tens_w;
  logic [DIGIT_BITS-1:0] ones_w;
  logic                  out_free;

  assign accept   = in_chan.valid && in_chan.ready;
  assign tick_inc = tick_r + 1'b1;
  assign win_end  = tick_inc > window_r;
  assign is_light = in_chan.channel == CH_LIGHT;
  assign cur_sum  = is_light ? light_sum_r : temp_sum_r;
  assign cur_cnt  = is_light ? light_cnt_r : temp_cnt_r;

  // a window that ends restarts the channel before the current sample goes in
  assign base_sum = win_end ? '0 : cur_sum;
  assign base_cnt = win_end ? '0 : cur_cnt;
  assign add_val  = is_light ? SUM_BITS'(in_chan.sample)
                             : SUM_BITS'(in_chan.sample >> TEMP_SHIFT);
  assign sum_nxt  = base_sum + add_val;
  assign cnt_nxt  = base_cnt + 1'b1;

  assign numer     = {1'b0, cur_sum} + NUM_BITS'(cur_cnt >> 1);
  assign div_start = accept && win_end && (cur_cnt != '0);

  tcaba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (numer),
    .divisor  (cur_cnt),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // digit split: drop thousands, then reciprocal multiply for hundreds and tens
  assign rest      = (avg_r >= THOUSAND) ? avg_r - THOUSAND : avg_r;
  assign hund_prod = 16'(rest) * RECIP_100;
  assign hund_w    = hund_prod[15:12];
  assign rem_w     = 7'(rest - AVG_BITS'(hund_w) * HUNDRED);
  assign tens_prod = 15'(rem_r) * RECIP_10;
  assign tens_w    = tens_prod[14:11];
  assign ones_w    = DIGIT_BITS'(rem_r - 7'(tens_w) * TEN);

  assign out_free  = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RESET;
      tick_r      <= '0;
      temp_sum_r  <= '0;
      temp_cnt_r  <= '0;
      light_sum_r <= '0;
      light_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      // a result loaded in the last digit state refills the register instead
      if (out_valid_r && out_chan.ready && state_r != ST_DIG2) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            tick_r <= win_end ? '0 : tick_inc;
            if (is_light) begin
              if (win_end || light_cnt_r != COUNT_MAX) begin
                light_sum_r <= sum_nxt;
                light_cnt_r <= cnt_nxt;
              end
            end else begin
              if (win_end || temp_cnt_r != COUNT_MAX) begin
                temp_sum_r <= sum_nxt;
                temp_cnt_r <= cnt_nxt;
              end
            end
            if (win_end) begin
              res_chan_r  <= in_chan.channel;
              res_empty_r <= cur_cnt == '0;
              avg_r       <= '0;
              state_r     <= (cur_cnt == '0) ? ST_DIG1 : ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            avg_r   <= div_quo[AVG_BITS-1:0];
            state_r <= ST_DIG1;
          end
        end
        ST_DIG1: begin
          hund_r  <= hund_w;
          rem_r   <= rem_w;
          state_r <= ST_DIG2;
        end
        ST_DIG2: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_chan_r  <= res_chan_r;
            out_avg_r   <= avg_r;
            out_empty_r <= res_empty_r;
            out_hund_r  <= hund_r;
            out_tens_r  <= tens_w;
            out_ones_r  <= ones_w;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_chan.ready           = state_r == ST_IDLE;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.result_channel = out_chan_r;
  assign out_chan.average        = out_avg_r;
  assign out_chan.empty_res      = out_empty_r;
  assign out_chan.hundreds       = out_hund_r;
  assign out_chan.tens           = out_tens_r;
  assign out_chan.ones           = out_ones_r;

  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider finished outside divide state");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.empty_res |-> out_chan.average == '0)
    else $error("empty result with non-zero average");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.hundreds < 4'd10) && (out_chan.tens < 4'd10)
                       && (out_chan.ones < 4'd10))
    else $error("decimal digit out of range");

endmodule
